// File: sv/sorted_array_list_engine_top_macros.svh
// Assertion helpers for the sorted list engine.
`ifndef SORTED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH
`define SORTED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH

// Clocked property check, quiet during reset.
`define SALE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be seen.
`define SALE_NEVER(lbl, cond, msg) \
   `SALE_ASSERT(lbl, !(cond), msg)

`endif

// File: sv/sale_pkg.sv
`timescale 1ns / 1ps

package sale_pkg;

   typedef enum logic [2:0] {
      MODE_INSERT = 3'd0,
      MODE_FIND   = 3'd1,
      MODE_DELETE = 3'd2,
      MODE_UPDATE = 3'd3,
      MODE_READ   = 3'd4,
      MODE_CLEAR  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_BAD_POS   = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_FROM_LOWER = 2'd2,
      CELL_FROM_UPPER = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
      logic [5:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         found_position;
      logic signed [31:0] item_value;
      logic [6:0]         count;
   } rsp_type;

   typedef struct packed {
      logic               capture;
      logic signed [31:0] value;
      logic [5:0]         position;
   } probe_type;

   typedef struct packed {
      logic le;
      logic ge;
      logic eq;
   } flags_type;

endpackage

// File: sv/sale_cell.sv
`timescale 1ns / 1ps

module sale_cell #(
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  sale_pkg::probe_type      probe,
   input  sale_pkg::cell_op_type    op,
   input  logic signed [31:0]       load_data,
   input  logic signed [31:0]       lower_entry,
   input  logic signed [31:0]       upper_entry,
   output logic signed [31:0]       entry,
   output sale_pkg::flags_type      flags,
   output logic signed [31:0]       sel_entry
);

   logic signed [31:0]  entry_ff, entry_in;
   sale_pkg::flags_type flags_ff, flags_in;
   logic signed [31:0]  sel_ff, sel_in;

   always_comb begin
      flags_in.le = (entry_ff <= probe.value);
      flags_in.ge = (entry_ff >= probe.value);
      flags_in.eq = (entry_ff == probe.value);
      sel_in      = (32'(probe.position) == 32'(IDX)) ? entry_ff : '0;
   end

   always_comb begin
      case (op)
         sale_pkg::CELL_LOAD:       entry_in = load_data;
         sale_pkg::CELL_FROM_LOWER: entry_in = lower_entry;
         sale_pkg::CELL_FROM_UPPER: entry_in = upper_entry;
         default:                   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (probe.capture) begin
         flags_ff <= flags_in;
         sel_ff   <= sel_in;
      end
   end

   assign entry     = entry_ff;
   assign flags     = flags_ff;
   assign sel_entry = sel_ff;

endmodule

// File: sv/sale_scan.sv
`timescale 1ns / 1ps

module sale_scan #(
   parameter int CAPACITY = 64
) (
   input  logic [CAPACITY-1:0] valid,
   input  logic [CAPACITY-1:0] le_vec,
   input  logic [CAPACITY-1:0] ge_vec,
   input  logic [CAPACITY-1:0] eq_vec,
   output logic [CAPACITY-1:0] ins_mask,
   output logic                found,
   output logic [5:0]          found_idx
);

   logic [CAPACITY-1:0] le_v, le_rev, le_top, below;
   logic [CAPACITY-1:0] ge_v, ge_first;

   always_comb begin
      le_v = le_vec & valid;
      ge_v = ge_vec & valid;
      for (int i = 0; i < CAPACITY; i++) begin
         le_rev[i] = le_v[CAPACITY-1-i];
      end
      // highest entry <= value, reversed to a lowest-set pick
      le_top = le_rev & (~le_rev + 1'b1);
      below  = le_top - 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
         ins_mask[i] = below[CAPACITY-1-i];
      end
      ge_first  = ge_v & (~ge_v + 1'b1);
      found     = |(ge_first & eq_vec);
      found_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (ge_first[i]) begin
            found_idx = found_idx | 6'(i);
         end
      end
   end

endmodule

// File: sv/sorted_array_list_engine_top.sv
`timescale 1ns / 1ps
// Channel   Ports                               Handshake
// request   req_item (mode, value, position)    start & !busy
// response  rsp_item (status, found_position,   rsp_strobe, one cycle
//           item_value, count)
//
// Per beat, the accept edge latches the request and every cell's
// compare flags; the next edge shifts the cell row and registers the response.
// busy is high for the one cycle in between; rsp_strobe follows for one cycle.
// Synchronous reset empties the list; entry storage is not cleared.
// The receiver cannot stall, so nothing backs up past the response register.

`include "sorted_array_list_engine_top_macros.svh"

module sorted_array_list_engine_top #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sale_pkg::req_type req_item,
   output logic              rsp_strobe,
   output sale_pkg::rsp_type rsp_item
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 6) ? CW : 6;

   sale_pkg::state_type state_ff, state_in;
   sale_pkg::req_type   req_ff;
   logic [CW-1:0]       count_ff, count_in;
   sale_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic                accept;
   sale_pkg::probe_type probe;

   logic signed [31:0]    entry_w [CAPACITY];
   logic signed [31:0]    sel_w   [CAPACITY];
   sale_pkg::flags_type   flags_w [CAPACITY];
   sale_pkg::cell_op_type op_w    [CAPACITY];

   logic [CAPACITY-1:0] valid, le_vec, ge_vec, eq_vec, ins_mask;
   logic                found;
   logic [5:0]          found_idx;
   logic signed [31:0]  read_item;
   logic                full, bad_pos;
   logic [PW-1:0]       pos_ext;

   assign accept         = start && !busy;
   assign probe.capture  = accept;
   assign probe.value    = req_item.value;
   assign probe.position = req_item.position;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] lower_w, upper_w;
      if (g == 0) begin : g_lo
         assign lower_w = entry_w[g];
      end else begin : g_lo
         assign lower_w = entry_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_up
         assign upper_w = entry_w[g];
      end else begin : g_up
         assign upper_w = entry_w[g+1];
      end
      sale_cell #(.IDX(g)) u_cell (
         .clock       (clock),
         .probe       (probe),
         .op          (op_w[g]),
         .load_data   (req_ff.value),
         .lower_entry (lower_w),
         .upper_entry (upper_w),
         .entry       (entry_w[g]),
         .flags       (flags_w[g]),
         .sel_entry   (sel_w[g])
      );
      assign valid[g]  = (CW'(g) < count_ff);
      assign le_vec[g] = flags_w[g].le;
      assign ge_vec[g] = flags_w[g].ge;
      assign eq_vec[g] = flags_w[g].eq;
   end

   sale_scan #(.CAPACITY(CAPACITY)) u_scan (
      .valid     (valid),
      .le_vec    (le_vec),
      .ge_vec    (ge_vec),
      .eq_vec    (eq_vec),
      .ins_mask  (ins_mask),
      .found     (found),
      .found_idx (found_idx)
   );

   always_comb begin
      read_item = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_item = read_item | sel_w[i];
      end
   end

   assign full    = (count_ff == CW'(CAPACITY));
   assign pos_ext = PW'(req_ff.position);
   assign bad_pos = !(pos_ext < PW'(count_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sale_pkg::ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         op_w[i] = sale_pkg::CELL_HOLD;
      end
      unique case (state_ff)
         sale_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = sale_pkg::ST_EXEC;
            end
         end
         sale_pkg::ST_EXEC: begin
            state_in                = sale_pkg::ST_IDLE;
            rsp_strobe_in           = 1'b1;
            rsp_in.status           = sale_pkg::STATUS_OK;
            rsp_in.found_position   = '0;
            rsp_in.item_value       = '0;
            unique case (req_ff.mode)
               sale_pkg::MODE_INSERT: begin
                  if (full) begin
                     rsp_in.status = sale_pkg::STATUS_FULL;
                  end else begin
                     for (int i = 0; i < CAPACITY; i++) begin
                        if (ins_mask[i]) begin
                           if (i == 0 || !ins_mask[(i == 0) ? 0 : i - 1]) begin
                              op_w[i] = sale_pkg::CELL_LOAD;
                           end else begin
                              op_w[i] = sale_pkg::CELL_FROM_LOWER;
                           end
                        end
                     end
                     count_in = count_ff + 1'b1;
                  end
               end
               sale_pkg::MODE_FIND: begin
                  if (found) begin
                     rsp_in.found_position = found_idx;
                  end else begin
                     rsp_in.status = sale_pkg::STATUS_NOT_FOUND;
                  end
               end
               sale_pkg::MODE_DELETE: begin
                  if (bad_pos) begin
                     rsp_in.status = sale_pkg::STATUS_BAD_POS;
                  end else begin
                     for (int i = 0; i < CAPACITY; i++) begin
                        if (PW'(i) >= pos_ext) begin
                           op_w[i] = sale_pkg::CELL_FROM_UPPER;
                        end
                     end
                     count_in = count_ff - 1'b1;
                  end
               end
               sale_pkg::MODE_UPDATE: begin
                  if (bad_pos) begin
                     rsp_in.status = sale_pkg::STATUS_BAD_POS;
                  end else begin
                     for (int i = 0; i < CAPACITY; i++) begin
                        if (PW'(i) == pos_ext) begin
                           op_w[i] = sale_pkg::CELL_LOAD;
                        end
                     end
                  end
               end
               sale_pkg::MODE_READ: begin
                  if (bad_pos) begin
                     rsp_in.status = sale_pkg::STATUS_BAD_POS;
                  end else begin
                     rsp_in.item_value = read_item;
                  end
               end
               sale_pkg::MODE_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
            rsp_in.count = 7'(count_in);
         end
         default: begin
            state_in = sale_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff == sale_pkg::ST_EXEC);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `SALE_ASSERT(a_accept_busy, accept |=> busy, "accepted beat did not raise busy")
   `SALE_ASSERT(a_strobe_after_exec, rsp_strobe |-> $past(state_ff == sale_pkg::ST_EXEC), "response without execute cycle")
   `SALE_NEVER(a_count_range, count_ff > CW'(CAPACITY), "entry count above capacity")
   `SALE_ASSERT(a_full_on_insert, (rsp_strobe && rsp_item.status == sale_pkg::STATUS_FULL) |-> $past(req_ff.mode == sale_pkg::MODE_INSERT), "full status on non-insert")

endmodule
